@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/gpg_pkg.sv @@
// Package: constants, codes and tables of the gradient pixel generator
`default_nettype none
package gpg_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int FRAC_BITS      = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FROM_COLOR   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TO_COLOR     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_X     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Y     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXPONENT     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIRECTION    = 3'd7;

   localparam logic [1:0] DIR_VERT   = 2'd0;
   localparam logic [1:0] DIR_HORIZ  = 2'd1;
   localparam logic [1:0] DIR_CIRCLE = 2'd2;
   localparam logic [1:0] DIR_NONE   = 2'd3;

   // how the weight of a pixel is settled
   typedef enum logic [1:0] {
      KIND_POW   = 2'd0,
      KIND_ZERO  = 2'd1,
      KIND_ONE   = 2'd2,
      KIND_BLACK = 2'd3
   } weight_kind_type;

   typedef logic [30:0] fac_array_type [FRAC_BITS];

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bt;
      v  = val;
      r  = 64'd0;
      bt = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bt != 64'd0) begin
            if (v >= r + bt) begin
               v = v - (r + bt);
               r = (r >> 1) + bt;
            end else begin
               r = r >> 1;
            end
            bt = bt >> 2;
         end
      end
      return r;
   endfunction

   // factors 2^-(2^(b-16)) in Q1.30, from repeated square roots of 2^59
   function automatic fac_array_type fac_table();
      fac_array_type t;
      logic [63:0]   f;
      f = isqrt64(64'd1 << 59);
      t[FRAC_BITS-1] = f[30:0];
      for (int i = FRAC_BITS - 1; i > 0; i--) begin
         f = isqrt64(f << 30);
         t[i-1] = f[30:0];
      end
      return t;
   endfunction

   localparam fac_array_type FAC = fac_table();

endpackage
`default_nettype wire

@@ rtl/gpg_req_if.sv @@
// Interfaces of the pixel request and colour response channels
`default_nettype none
interface gpg_req_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   modport source(output valid, pixel_x, pixel_y, input ready);
   modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

interface gpg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source(output valid, red, green, blue, input ready);
   modport sink(input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

@@ rtl/gradient_pixel_generator.sv @@
// Top level: pipelined gradient colour generator for one pixel per clock
//
//  channel    dir  payload                     handshake
//  req_chan   in   pixel_x, pixel_y            valid/ready
//  rsp_chan   out  red, green, blue            valid/ready
//  csr_*      in   csr_index, csr_write_data   csr_write_enable
//
// One transaction per clock in and out; the pipeline is built around the
// 16-step divider, 16-step log squaring chain and 16-step power product.
// reset (synchronous) clears the stage valid bits and loads register defaults.
// A stalled response freezes every stage; req_chan.ready is low only then.
`default_nettype none
module gradient_pixel_generator #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gpg_req_if.sink                              req_chan,
   gpg_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [gpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gpg_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
`include "assert_macros.svh"

   localparam int C   = COORD_BITS;
   localparam int SW  = C + 1;          // image size / radius width
   localparam int XW  = C + 3;          // signed working width
   localparam int DW  = 2 * C + 3;      // squared distance width
   localparam int FB  = gpg_pkg::FRAC_BITS;

   // stage map
   localparam int ST_S1   = 0;
   localparam int ST_S2   = 1;
   localparam int ST_DIV0 = 2;
   localparam int ST_NORM = ST_DIV0 + FB;
   localparam int ST_SQ0  = ST_NORM + 1;
   localparam int ST_LG   = ST_SQ0 + FB;
   localparam int ST_RND  = ST_LG + 1;
   localparam int ST_EX0  = ST_RND + 1;
   localparam int ST_SHF  = ST_EX0 + FB;
   localparam int ST_OUT  = ST_SHF + 1;
   localparam int NST     = ST_OUT + 1;

   localparam logic signed [XW-1:0] ONE_S = XW'(1);
   localparam logic [30:0] Y_ONE = 31'h4000_0000;

   typedef struct packed {
      logic [SW-1:0] mx;
      logic [SW-1:0] my;
      logic [SW-1:0] rx;
      logic [SW-1:0] ry;
      logic          circ;
      logic          black;
   } s1_type;

   typedef struct packed {
      logic [DW-1:0] num;
      logic [DW-1:0] den;
      logic          circ;
      logic          black;
   } s2_type;

   typedef struct packed {
      logic [DW-1:0]            rem;
      logic [DW-1:0]            den;
      logic [FB-1:0]            q;
      gpg_pkg::weight_kind_type kind;
      logic                     circ;
   } div_type;

   typedef struct packed {
      logic [FB:0]              x;
      logic [4:0]               k;
      logic [FB-1:0]            f;
      gpg_pkg::weight_kind_type kind;
      logic                     circ;
   } sq_type;

   typedef struct packed {
      logic [36:0]              p;
      gpg_pkg::weight_kind_type kind;
      logic                     circ;
   } lg_type;

   typedef struct packed {
      logic [30:0]              y;
      logic [4:0]               n;
      logic [FB-1:0]            g;
      gpg_pkg::weight_kind_type kind;
   } ex_type;

   typedef struct packed {
      logic [FB:0] a;
      logic        black;
   } shf_type;

   // ---------------- configuration registers ----------------
   logic [23:0]   from_color_ff, to_color_ff;
   logic [SW-1:0] image_width_ff, image_height_ff;
   logic [C-1:0]  center_x_ff, center_y_ff;
   logic [15:0]   exponent_ff;
   logic [1:0]    direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         from_color_ff   <= 24'h000000;
         to_color_ff     <= 24'hFFFFFF;
         image_width_ff  <= SW'(640);
         image_height_ff <= SW'(480);
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         exponent_ff     <= 16'd4096;
         direction_ff    <= gpg_pkg::DIR_VERT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gpg_pkg::REG_FROM_COLOR:   from_color_ff   <= csr_write_data[23:0];
            gpg_pkg::REG_TO_COLOR:     to_color_ff     <= csr_write_data[23:0];
            gpg_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[SW-1:0];
            gpg_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_write_data[SW-1:0];
            gpg_pkg::REG_CENTER_X:     center_x_ff     <= csr_write_data[C-1:0];
            gpg_pkg::REG_CENTER_Y:     center_y_ff     <= csr_write_data[C-1:0];
            gpg_pkg::REG_EXPONENT:     exponent_ff     <= csr_write_data[15:0];
            gpg_pkg::REG_DIRECTION:    direction_ff    <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // every stage moves together; only a held response stops them
   logic           adv;
   logic [NST-1:0] vld_ff, vld_in;

   assign adv            = !vld_ff[ST_OUT] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign vld_in         = {vld_ff[NST-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- S1: signed distances and radii ----------------
   s1_type s1_in, s1_ff;
   logic signed [XW-1:0] cx_s, cy_s, px_s, py_s, wd_s, ht_s;
   logic signed [XW-1:0] w_s, h_s, ww_s, hh_s, dx_s, dy_s, adx_s, ady_s;
   logic signed [XW-1:0] sz_s, cs_s, p_s, nn_s, r2_s, rr_s, dd_s, add_s;
   logic                 vert;

   always_comb begin
      cx_s = signed'(XW'(center_x_ff));
      cy_s = signed'(XW'(center_y_ff));
      px_s = signed'(XW'(req_chan.pixel_x));
      py_s = signed'(XW'(req_chan.pixel_y));
      wd_s = signed'(XW'(image_width_ff));
      ht_s = signed'(XW'(image_height_ff));
      // circle: farthest corner and pixel offset
      w_s   = wd_s - cx_s - ONE_S;
      h_s   = ht_s - cy_s - ONE_S;
      ww_s  = (cx_s < w_s) ? w_s : cx_s;
      hh_s  = (cy_s < h_s) ? h_s : cy_s;
      dx_s  = cx_s - px_s;
      dy_s  = cy_s - py_s;
      adx_s = dx_s[XW-1] ? -dx_s : dx_s;
      ady_s = dy_s[XW-1] ? -dy_s : dy_s;
      // linear: rows for vertical, columns for horizontal
      vert  = (direction_ff == gpg_pkg::DIR_VERT);
      sz_s  = vert ? ht_s : wd_s;
      cs_s  = vert ? cy_s : cx_s;
      p_s   = vert ? py_s : px_s;
      nn_s  = sz_s - ONE_S;
      r2_s  = nn_s - cs_s;
      rr_s  = (cs_s < r2_s) ? r2_s : cs_s;
      dd_s  = p_s - cs_s;
      add_s = dd_s[XW-1] ? -dd_s : dd_s;

      s1_in.circ  = (direction_ff == gpg_pkg::DIR_CIRCLE);
      s1_in.black = (direction_ff == gpg_pkg::DIR_NONE);
      if (s1_in.circ) begin
         s1_in.mx = adx_s[SW-1:0];
         s1_in.my = ady_s[SW-1:0];
         s1_in.rx = ww_s[SW-1:0];
         s1_in.ry = hh_s[SW-1:0];
      end else begin
         s1_in.mx = add_s[SW-1:0];
         s1_in.my = '0;
         s1_in.rx = rr_s[SW-1:0];
         s1_in.ry = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) s1_ff <= s1_in;
   end

   // ---------------- S2: squares (circle) ----------------
   s2_type s2_in, s2_ff;
   logic [2*SW-1:0] mxx, myy, rxx, ryy;

   always_comb begin
      mxx = s1_ff.mx * s1_ff.mx;
      myy = s1_ff.my * s1_ff.my;
      rxx = s1_ff.rx * s1_ff.rx;
      ryy = s1_ff.ry * s1_ff.ry;
      s2_in.circ  = s1_ff.circ;
      s2_in.black = s1_ff.black;
      if (s1_ff.circ) begin
         s2_in.num = DW'(mxx) + DW'(myy);
         s2_in.den = DW'(rxx) + DW'(ryy);
      end else begin
         s2_in.num = DW'(s1_ff.mx);
         s2_in.den = DW'(s1_ff.rx);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) s2_ff <= s2_in;
   end

   // ---------------- ratio: restoring divider, one bit a stage ----------------
   div_type div_first;
   div_type div_ff [FB];

   always_comb begin
      div_first.rem  = s2_ff.num;
      div_first.den  = s2_ff.den;
      div_first.q    = '0;
      div_first.circ = s2_ff.circ;
      if (s2_ff.black) begin
         div_first.kind = gpg_pkg::KIND_BLACK;
      end else if (s2_ff.den == '0) begin
         div_first.kind = gpg_pkg::KIND_ZERO;
      end else if (exponent_ff == 16'd0) begin
         div_first.kind = gpg_pkg::KIND_ONE;
      end else if (s2_ff.num >= s2_ff.den) begin
         div_first.kind = gpg_pkg::KIND_ONE;  // at or beyond the rim
      end else begin
         div_first.kind = gpg_pkg::KIND_POW;
      end
   end

   for (genvar j = 0; j < FB; j++) begin : g_div
      div_type       src, nxt;
      logic [DW:0]   rem2;
      if (j == 0) begin : g_first
         assign src = div_first;
      end else begin : g_next
         assign src = div_ff[j-1];
      end
      always_comb begin
         nxt  = src;
         rem2 = {src.rem, 1'b0};
         if (rem2 >= {1'b0, src.den}) begin
            nxt.rem = DW'(rem2 - {1'b0, src.den});
            nxt.q   = {src.q[FB-2:0], 1'b1};
         end else begin
            nxt.rem = rem2[DW-1:0];
            nxt.q   = {src.q[FB-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) div_ff[j] <= nxt;
      end
   end

   // ---------------- normalise q into [1,2) ----------------
   sq_type norm_in, norm_ff;
   logic [FB-1:0] qv;

   always_comb begin
      qv           = div_ff[FB-1].q;
      norm_in.circ = div_ff[FB-1].circ;
      norm_in.kind = div_ff[FB-1].kind;
      norm_in.f    = '0;
      norm_in.k    = 5'd16;
      for (int b = 0; b < FB; b++) begin
         if (qv[b]) norm_in.k = 5'(FB - b);
      end
      if (norm_in.kind == gpg_pkg::KIND_POW && qv == '0) begin
         norm_in.kind = gpg_pkg::KIND_ZERO;
      end
      norm_in.x = (FB+1)'(qv) << norm_in.k;
   end

   always_ff @(posedge clock) begin
      if (adv) norm_ff <= norm_in;
   end

   // ---------------- log2 fraction: one squaring a stage ----------------
   sq_type sq_ff [FB];

   for (genvar j = 0; j < FB; j++) begin : g_sq
      sq_type          src, nxt;
      logic [2*FB+1:0] prod;
      logic [FB+1:0]   xs;
      if (j == 0) begin : g_first
         assign src = norm_ff;
      end else begin : g_next
         assign src = sq_ff[j-1];
      end
      always_comb begin
         nxt  = src;
         prod = src.x * src.x;
         xs   = prod[2*FB+1:FB];
         if (xs[FB+1]) begin
            nxt.x = xs[FB+1:1];
            nxt.f = {src.f[FB-2:0], 1'b1};
         end else begin
            nxt.x = xs[FB:0];
            nxt.f = {src.f[FB-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) sq_ff[j] <= nxt;
      end
   end

   // ---------------- P = -log2(q) * exponent ----------------
   lg_type lg_in, lg_ff;
   logic [20:0] lg;

   always_comb begin
      lg         = {sq_ff[FB-1].k, 16'b0} - 21'(sq_ff[FB-1].f);
      lg_in.p    = 37'(lg) * 37'(exponent_ff);
      lg_in.kind = sq_ff[FB-1].kind;
      lg_in.circ = sq_ff[FB-1].circ;
   end

   always_ff @(posedge clock) begin
      if (adv) lg_ff <= lg_in;
   end

   // ---------------- round to Q.16, split n and g ----------------
   ex_type rnd_in, rnd_ff;
   logic [37:0] p16w;

   always_comb begin
      // circle works on squared distance: exponent halved
      if (lg_ff.circ) p16w = (38'(lg_ff.p) + 38'd4096) >> 13;
      else            p16w = (38'(lg_ff.p) + 38'd2048) >> 12;
      rnd_in.y    = Y_ONE;
      rnd_in.g    = p16w[FB-1:0];
      rnd_in.n    = p16w[FB+4:FB];
      rnd_in.kind = lg_ff.kind;
      if (lg_ff.kind == gpg_pkg::KIND_POW && p16w[37:FB] > 22'd16) begin
         rnd_in.kind = gpg_pkg::KIND_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rnd_ff <= rnd_in;
   end

   // ---------------- 2^-g: one factor a stage, top bit first ----------------
   ex_type ex_ff [FB];

   for (genvar j = 0; j < FB; j++) begin : g_ex
      ex_type      src, nxt;
      logic [61:0] prod;
      if (j == 0) begin : g_first
         assign src = rnd_ff;
      end else begin : g_next
         assign src = ex_ff[j-1];
      end
      always_comb begin
         nxt  = src;
         prod = 62'(src.y) * 62'(gpg_pkg::FAC[FB-1-j]);
         if (src.g[FB-1-j]) nxt.y = 31'((prod + (62'd1 << 29)) >> 30);
      end
      always_ff @(posedge clock) begin
         if (adv) ex_ff[j] <= nxt;
      end
   end

   // ---------------- a = 2^-g / 2^n in Q1.16 ----------------
   shf_type shf_in, shf_ff;
   logic [4:0]  sh;
   logic [31:0] aw;

   always_comb begin
      sh  = ex_ff[FB-1].n + 5'd14;
      aw  = (32'(ex_ff[FB-1].y) + (32'd1 << (sh - 5'd1))) >> sh;
      shf_in.black = (ex_ff[FB-1].kind == gpg_pkg::KIND_BLACK);
      case (ex_ff[FB-1].kind)
         gpg_pkg::KIND_POW: shf_in.a = aw[FB:0];
         gpg_pkg::KIND_ONE: shf_in.a = (FB+1)'(1) << FB;
         default:           shf_in.a = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) shf_ff <= shf_in;
   end

   // ---------------- blend, round, saturate ----------------
   logic [7:0] out_in [3];
   logic [7:0] out_ff [3];

   always_comb begin
      logic [7:0]         fc, tc;
      logic signed [26:0] v, vr;
      for (int c = 0; c < 3; c++) begin
         fc = from_color_ff[8*(2-c) +: 8];
         tc = to_color_ff[8*(2-c) +: 8];
         v  = signed'(27'({fc, 16'b0}))
              + (signed'(27'(tc)) - signed'(27'(fc))) * signed'(27'(shf_ff.a));
         if (v[26]) v = '0;
         vr = (v + 27'sd32768) >>> 16;
         if (shf_ff.black)      out_in[c] = 8'd0;
         else if (vr > 27'sd255) out_in[c] = 8'd255;
         else                    out_in[c] = vr[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_chan.valid = vld_ff[ST_OUT];
   assign rsp_chan.red   = out_ff[0];
   assign rsp_chan.green = out_ff[1];
   assign rsp_chan.blue  = out_ff[2];

   // ---------------- assertions ----------------
   `ASSERT_CLK(a_stall_freezes, clock, reset, !adv |=> $stable(vld_ff), "stage valids moved in a stall")
   `ASSERT_CLK(a_entry, clock, reset, req_chan.valid && req_chan.ready |=> vld_ff[ST_S1], "accepted transaction not in first stage")
   `ASSERT_NEVER(a_power_range, clock, reset, vld_ff[ST_SHF-1] && ex_ff[FB-1].y > Y_ONE, "power product above one")
   `ASSERT_NEVER(a_weight_range, clock, reset, vld_ff[ST_SHF] && shf_ff.a > ((FB+1)'(1) << FB), "weight above one")

endmodule
`default_nettype wire
